// ----- rtl/cau_pkg.sv -----
//------------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes and widths for the complex arithmetic unit.
//------------------------------------------------------------------------------
`default_nettype none
package cau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CMD_BITS      = 3;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MAG = 3'd4
    } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/complex_arithmetic_unit.sv -----
// done follows the accepting edge through the operand, product and combine registers,
// the one-bit-per-stage divide and square-root pipeline and the output register.
// Throughput: one operation per cycle; busy is always low.
// The receiver cannot stall; each result shows for one cycle with done.
// Reset (rst_n, asynchronous, active low) clears all valid bits.
//------------------------------------------------------------------------------
// Complex arithmetic unit
// Top level: command port into the pipelined complex datapath.
//------------------------------------------------------------------------------
`default_nettype none
module complex_arithmetic_unit #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [cau_pkg::CMD_BITS-1:0] cmd,
    input  wire logic signed [WORD_BITS-1:0]  a_re,
    input  wire logic signed [WORD_BITS-1:0]  a_im,
    input  wire logic signed [WORD_BITS-1:0]  b_re,
    input  wire logic signed [WORD_BITS-1:0]  b_im,
    output logic                              done,
    output logic signed [WORD_BITS-1:0]       res_re,
    output logic signed [WORD_BITS-1:0]       res_im,
    output logic                              div_zero,
    output logic                              overflow
);

    // The pipeline never stalls, so a beat is taken every cycle.
    assign busy = 1'b0;

    cau_pipe #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_cmd    (cmd),
        .in_a_re   (a_re),
        .in_a_im   (a_im),
        .in_b_re   (b_re),
        .in_b_im   (b_im),
        .out_valid (done),
        .out_re    (res_re),
        .out_im    (res_im),
        .out_dz    (div_zero),
        .out_ovf   (overflow)
    );

endmodule
`default_nettype wire

// ----- rtl/cau_pipe.sv -----
//------------------------------------------------------------------------------
// Complex arithmetic datapath
// Pipelined add, subtract, multiply, divide and magnitude, one beat per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module cau_pipe #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [cau_pkg::CMD_BITS-1:0] in_cmd,
    input  wire logic signed [WORD_BITS-1:0] in_a_re,
    input  wire logic signed [WORD_BITS-1:0] in_a_im,
    input  wire logic signed [WORD_BITS-1:0] in_b_re,
    input  wire logic signed [WORD_BITS-1:0] in_b_im,
    output logic                             out_valid,
    output logic signed [WORD_BITS-1:0]      out_re,
    output logic signed [WORD_BITS-1:0]      out_im,
    output logic                             out_dz,
    output logic                             out_ovf
);

    // Product width and quotient/root widths.
    localparam int PW    = 2 * WORD_BITS;
    localparam int MW    = PW + 2;
    localparam int NW    = MW + FRAC_BITS;
    localparam int QB    = WORD_BITS + 1;
    localparam int RW    = PW + 2;

    typedef logic signed [MW-1:0] wide_t;
    typedef logic [NW-1:0]        num_t;

    // Stage 1: register operands.
    logic                          s1_v_reg;
    logic [cau_pkg::CMD_BITS-1:0]  s1_cmd_reg;
    logic signed [WORD_BITS-1:0]   s1_a_reg, s1_b_reg, s1_c_reg, s1_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= in_cmd;
        s1_a_reg   <= in_a_re;
        s1_b_reg   <= in_a_im;
        s1_c_reg   <= in_b_re;
        s1_d_reg   <= in_b_im;
    end

    // Stage 2: the four cross products, four squares, the sums for add and subtract, and the zero-divisor flag.
    logic                          s2_v_reg;
    logic [cau_pkg::CMD_BITS-1:0]  s2_cmd_reg;
    wide_t                         s2_ac_reg, s2_bd_reg, s2_bc_reg, s2_ad_reg;
    wide_t                         s2_cc_reg, s2_dd_reg, s2_aa_reg, s2_bb_reg;
    wide_t                         s2_sre_reg, s2_sim_reg;
    logic                          s2_bz_reg;
    wide_t                         s2_sre_next, s2_sim_next;

    always_comb
    begin
        if (s1_cmd_reg == cau_pkg::CMD_SUB)
        begin
            s2_sre_next = MW'(s1_a_reg) - MW'(s1_c_reg);
            s2_sim_next = MW'(s1_b_reg) - MW'(s1_d_reg);
        end
        else
        begin
            s2_sre_next = MW'(s1_a_reg) + MW'(s1_c_reg);
            s2_sim_next = MW'(s1_b_reg) + MW'(s1_d_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_cmd_reg <= s1_cmd_reg;
        s2_ac_reg  <= MW'(PW'(s1_a_reg) * PW'(s1_c_reg));
        s2_bd_reg  <= MW'(PW'(s1_b_reg) * PW'(s1_d_reg));
        s2_bc_reg  <= MW'(PW'(s1_b_reg) * PW'(s1_c_reg));
        s2_ad_reg  <= MW'(PW'(s1_a_reg) * PW'(s1_d_reg));
        s2_cc_reg  <= MW'(PW'(s1_c_reg) * PW'(s1_c_reg));
        s2_dd_reg  <= MW'(PW'(s1_d_reg) * PW'(s1_d_reg));
        s2_aa_reg  <= MW'(PW'(s1_a_reg) * PW'(s1_a_reg));
        s2_bb_reg  <= MW'(PW'(s1_b_reg) * PW'(s1_b_reg));
        s2_sre_reg <= s2_sre_next;
        s2_sim_reg <= s2_sim_next;
        s2_bz_reg  <= (s1_c_reg == '0) && (s1_d_reg == '0);
    end

    // Stage 3: combine products into signed real and imaginary values and the divisor c*c + d*d.
    logic                          s3_v_reg;
    logic [cau_pkg::CMD_BITS-1:0]  s3_cmd_reg;
    wide_t                         s3_re_reg, s3_im_reg;
    logic [RW-1:0]                 s3_den_reg;
    logic                          s3_bz_reg;
    wide_t                         s3_re_next, s3_im_next;

    always_comb
    begin
        case (s2_cmd_reg)
            cau_pkg::CMD_ADD, cau_pkg::CMD_SUB:
            begin
                s3_re_next = s2_sre_reg;
                s3_im_next = s2_sim_reg;
            end
            cau_pkg::CMD_MUL:
            begin
                s3_re_next = s2_ac_reg - s2_bd_reg;
                s3_im_next = s2_bc_reg + s2_ad_reg;
            end
            cau_pkg::CMD_DIV:
            begin
                s3_re_next = s2_ac_reg + s2_bd_reg;
                s3_im_next = s2_bc_reg - s2_ad_reg;
            end
            cau_pkg::CMD_MAG:
            begin
                s3_re_next = s2_aa_reg + s2_bb_reg;
                s3_im_next = '0;
            end
            default:
            begin
                s3_re_next = '0;
                s3_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_cmd_reg <= s2_cmd_reg;
        s3_re_reg  <= s3_re_next;
        s3_im_reg  <= s3_im_next;
        s3_den_reg <= RW'(s2_cc_reg + s2_dd_reg);
        s3_bz_reg  <= s2_bz_reg;
    end

    // Stage 4: sign and magnitude split; set up the iterative units.
    // Each lane of the divide is a restoring divider with one quotient bit
    // per stage; the square root shares the real lane's stages.
    typedef struct packed {
        logic [cau_pkg::CMD_BITS-1:0] cmd;
        logic                         bz;
        logic                         neg_re;
        logic                         neg_im;
        logic                         big_re;
        logic                         big_im;
        num_t                         n_re;
        num_t                         n_im;
        logic [RW-1:0]                r_re;
        logic [RW-1:0]                r_im;
        logic [QB-1:0]                q_re;
        logic [QB-1:0]                q_im;
        logic [RW-1:0]                den;
    } it_t;

    it_t           st_reg [QB+1];
    it_t           st_next [1:QB];
    it_t           st0_next;
    logic [QB:0]   st_v_reg;

    logic [MW-1:0] m_re, m_im;

    always_comb
    begin
        m_re = s3_re_reg[MW-1] ? MW'(-s3_re_reg) : MW'(s3_re_reg);
        m_im = s3_im_reg[MW-1] ? MW'(-s3_im_reg) : MW'(s3_im_reg);
        st0_next        = '0;
        st0_next.cmd    = s3_cmd_reg;
        st0_next.bz     = s3_bz_reg;
        st0_next.neg_re = s3_re_reg[MW-1];
        st0_next.neg_im = s3_im_reg[MW-1];
        st0_next.den    = s3_den_reg;
        // Quotient bits above QB cannot be resolved here; too_big flags them in the next stage.
        st0_next.n_re   = {m_re, {FRAC_BITS{1'b0}}};
        st0_next.n_im   = {m_im, {FRAC_BITS{1'b0}}};
        if (s3_cmd_reg == cau_pkg::CMD_MAG)
            st0_next.n_re = NW'(m_re);
        else if (s3_cmd_reg == cau_pkg::CMD_MUL)
        begin
            st0_next.n_re = NW'(m_re >> FRAC_BITS);
            st0_next.n_im = NW'(m_im >> FRAC_BITS);
        end
        else if (s3_cmd_reg == cau_pkg::CMD_DIV)
        begin
            // Dividend bits above the quotient range seed the remainder.
            st0_next.r_re = RW'(st0_next.n_re >> QB);
            st0_next.r_im = RW'(st0_next.n_im >> QB);
        end
    end

    // Quotient above the saturating range flags overflow without dividing.
    function automatic logic too_big(input num_t n, input logic [RW-1:0] d);
        logic [NW+QB:0] lim;
        begin
            lim     = (NW+QB+1)'(d) << QB;
            too_big = (NW+QB+1)'(n) >= lim;
        end
    endfunction

    always_comb
    begin
        logic [RW+1:0] tr, ti, rem_t, trial;
        tr    = '0;
        ti    = '0;
        rem_t = '0;
        trial = '0;
        for (int k = 1; k <= QB; k++)
        begin
            st_next[k] = st_reg[k-1];
            if (k == 1)
            begin
                st_next[k].big_re = too_big(st_reg[0].n_re, st_reg[0].den);
                st_next[k].big_im = too_big(st_reg[0].n_im, st_reg[0].den);
            end
            if (st_reg[k-1].cmd == cau_pkg::CMD_DIV)
            begin
                tr = {1'b0, st_reg[k-1].r_re, st_reg[k-1].n_re[QB-k]};
                ti = {1'b0, st_reg[k-1].r_im, st_reg[k-1].n_im[QB-k]};
                st_next[k].r_re = RW'(tr);
                st_next[k].r_im = RW'(ti);
                st_next[k].q_re = st_reg[k-1].q_re << 1;
                st_next[k].q_im = st_reg[k-1].q_im << 1;
                if (tr >= (RW+2)'(st_reg[k-1].den))
                begin
                    st_next[k].r_re = RW'(tr - (RW+2)'(st_reg[k-1].den));
                    st_next[k].q_re[0] = 1'b1;
                end
                if (ti >= (RW+2)'(st_reg[k-1].den))
                begin
                    st_next[k].r_im = RW'(ti - (RW+2)'(st_reg[k-1].den));
                    st_next[k].q_im[0] = 1'b1;
                end
            end
            else if (st_reg[k-1].cmd == cau_pkg::CMD_MAG)
            begin
                // One root bit per stage from the next pair of radicand bits.
                rem_t = {st_reg[k-1].r_re, st_reg[k-1].n_re[2*(QB-k) +: 2]};
                trial = (RW+2)'({st_reg[k-1].q_re, 2'b01});
                st_next[k].q_re = st_reg[k-1].q_re << 1;
                st_next[k].r_re = RW'(rem_t);
                if (rem_t >= trial)
                begin
                    st_next[k].r_re = RW'(rem_t - trial);
                    st_next[k].q_re[0] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_v_reg <= '0;
        else
            st_v_reg <= {st_v_reg[QB-1:0], s3_v_reg};
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= st0_next;
        for (int k = 1; k <= QB; k++)
            st_reg[k] <= st_next[k];
    end

    // Final stage: choose magnitude source, saturate and sign.
    it_t           fin;
    logic [NW:0]   mag_re, mag_im;
    logic          ovf_re, ovf_im;
    logic signed [WORD_BITS-1:0] w_re, w_im;

    function automatic logic [WORD_BITS:0] sat(input logic neg, input logic [NW:0] m,
                                               output logic ovf);
        logic [NW:0] maxp;
        begin
            maxp = (NW+1)'((64'd1 << (WORD_BITS-1)) - 64'd1);
            ovf  = 1'b0;
            if (!neg && m > maxp)
            begin
                ovf = 1'b1;
                sat = (WORD_BITS+1)'(maxp);
            end
            else if (neg && m > maxp + 1'b1)
            begin
                ovf = 1'b1;
                sat = (WORD_BITS+1)'(-(maxp + 1'b1));
            end
            else
                sat = neg ? (WORD_BITS+1)'(-m) : (WORD_BITS+1)'(m);
        end
    endfunction

    always_comb
    begin
        logic [WORD_BITS:0] t_re, t_im;
        fin = st_reg[QB];
        case (fin.cmd)
            cau_pkg::CMD_DIV:
            begin
                mag_re = fin.big_re ? '1 : (NW+1)'(fin.q_re);
                mag_im = fin.big_im ? '1 : (NW+1)'(fin.q_im);
            end
            cau_pkg::CMD_MAG:
            begin
                mag_re = (NW+1)'(fin.q_re);
                mag_im = '0;
            end
            default:
            begin
                mag_re = (NW+1)'(fin.n_re >> ((fin.cmd == cau_pkg::CMD_MUL) ? 0 : FRAC_BITS));
                mag_im = (NW+1)'(fin.n_im >> ((fin.cmd == cau_pkg::CMD_MUL) ? 0 : FRAC_BITS));
            end
        endcase
        t_re = sat(fin.neg_re && fin.cmd != cau_pkg::CMD_MAG, mag_re, ovf_re);
        t_im = sat(fin.neg_im && fin.cmd != cau_pkg::CMD_MAG, mag_im, ovf_im);
        w_re = WORD_BITS'(t_re);
        w_im = WORD_BITS'(t_im);
    end

    logic bad_cmd;
    logic dz;
    assign bad_cmd = fin.cmd > cau_pkg::CMD_BITS'(cau_pkg::CMD_MAG);
    assign dz      = (fin.cmd == cau_pkg::CMD_DIV) && fin.bz;

    logic                        o_v_reg;
    logic signed [WORD_BITS-1:0] o_re_reg, o_im_reg;
    logic                        o_dz_reg, o_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else
            o_v_reg <= st_v_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        o_re_reg  <= (bad_cmd || dz) ? '0 : w_re;
        o_im_reg  <= (bad_cmd || dz) ? '0 : w_im;
        o_dz_reg  <= dz;
        o_ovf_reg <= !(bad_cmd || dz) && (ovf_re || ovf_im);
    end

    assign out_valid = o_v_reg;
    assign out_re    = o_re_reg;
    assign out_im    = o_im_reg;
    assign out_dz    = o_dz_reg;
    assign out_ovf   = o_ovf_reg;

endmodule
`default_nettype wire
